FILE: hdl/vrhr_pkg.sv
// ----------------------------------------------------------------------------
// vrhr_pkg: shared types and constants for the record history ring
// Port widths, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package vrhr_pkg;

  localparam int STORE_BYTES_DEF = 4096;
  localparam int MAX_ENTRIES_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int LEN_W   = 11;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;
  localparam int OFF_W   = 11;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd1;
  localparam logic [STAT_W-1:0] ST_ADD_OPEN = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_ADD   = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_LEN,
    RES_LEN_BYTE
  } res_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic              latch;     // capture the input transaction
    logic              desc_rd;   // read descriptor memory
    logic              desc_wr;   // commit a begin: write descriptor
    logic              byte_wr;   // commit an add: write one byte
    logic              evict;     // drop the oldest entry
    logic              byte_rd;   // read byte store
    logic              finish;    // load result registers
    logic [STAT_W-1:0] status;
    res_sel_t          res_sel;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd_code;
    logic             add_open;
    logic             too_long;
    logic             idx_bad;
    logic             need_evict;
    logic             off_bad;
  } dp_flags_t;

endpackage

FILE: hdl/variable_record_history_ring_top.sv
// ----------------------------------------------------------------------------
// variable_record_history_ring_top: history ring of variable-length lines
// Circular byte store plus a ring of line descriptors, command driven.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted at a clock edge where start is high and busy is
//   low; command, line_length, data_byte, entry_index and byte_offset are
//   sampled there. Exactly one result follows: done is high for one cycle
//   with status, entry_count, read_length and read_byte valid. The receiver
//   cannot stall; results must be taken in that cycle.
//   Add byte and refused commands finish at decode; a read in range first
//   reads the descriptor, then the byte unless the offset is out of range;
//   begin walks eviction (descriptor memory read, then update, per entry).
//   busy drops in the cycle done is high, so a new transaction may be
//   accepted alongside the result, also within an add-byte stream. Reset
//   (rst, synchronous) empties the ring and closes any open
//   add; store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module variable_record_history_ring_top #(
  parameter int STORE_BYTES = vrhr_pkg::STORE_BYTES_DEF,
  parameter int MAX_ENTRIES = vrhr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [vrhr_pkg::CMD_W-1:0]    command,
  input  logic [vrhr_pkg::LEN_W-1:0]    line_length,
  input  logic [vrhr_pkg::BYTE_W-1:0]   data_byte,
  input  logic [vrhr_pkg::INDEX_W-1:0]  entry_index,
  input  logic [vrhr_pkg::OFF_W-1:0]    byte_offset,
  output logic                          done,
  output logic [vrhr_pkg::STAT_W-1:0]   status,
  output logic [vrhr_pkg::COUNT_W-1:0]  entry_count,
  output logic [vrhr_pkg::LEN_W-1:0]    read_length,
  output logic [vrhr_pkg::BYTE_W-1:0]   read_byte
);

  vrhr_pkg::ctrl_cmd_t cmd;
  vrhr_pkg::dp_flags_t flags;

  vrhr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .flags (flags),
    .cmd   (cmd)
  );

  vrhr_datapath #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .line_length (line_length),
    .data_byte   (data_byte),
    .entry_index (entry_index),
    .byte_offset (byte_offset),
    .cmd         (cmd),
    .flags       (flags),
    .status      (status),
    .entry_count (entry_count),
    .read_length (read_length),
    .read_byte   (read_byte)
  );

endmodule

FILE: hdl/vrhr_ctrl.sv
// ----------------------------------------------------------------------------
// vrhr_ctrl: sequencer for the record history ring
// Decodes each transaction, walks eviction and steps the read path.
// ----------------------------------------------------------------------------
module vrhr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  vrhr_pkg::dp_flags_t flags,
  output vrhr_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EVICT_CHECK,
    S_EVICT_UPD,
    S_READ_DESC,
    S_READ_BYTE
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = vrhr_pkg::ST_OK;
    cmd.res_sel = vrhr_pkg::RES_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (flags.cmd_code)
          vrhr_pkg::CMD_BEGIN: begin
            if (flags.add_open) begin
              cmd.finish = 1'b1;
              cmd.status = vrhr_pkg::ST_ADD_OPEN;
            end else if (flags.too_long) begin
              cmd.finish = 1'b1;
              cmd.status = vrhr_pkg::ST_TOO_LONG;
            end else begin
              state_next = S_EVICT_CHECK;
            end
          end
          vrhr_pkg::CMD_ADD: begin
            cmd.finish = 1'b1;
            if (flags.add_open) begin
              cmd.byte_wr = 1'b1;
            end else begin
              cmd.status = vrhr_pkg::ST_NO_ADD;
            end
          end
          vrhr_pkg::CMD_READ: begin
            if (flags.idx_bad) begin
              cmd.finish = 1'b1;
              cmd.status = vrhr_pkg::ST_RANGE;
            end else begin
              cmd.desc_rd = 1'b1;
              state_next  = S_READ_DESC;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            cmd.status = vrhr_pkg::ST_RANGE;
          end
        endcase
      end
      S_EVICT_CHECK: begin
        if (flags.need_evict) begin
          cmd.desc_rd = 1'b1;
          state_next  = S_EVICT_UPD;
        end else begin
          cmd.desc_wr = 1'b1;
          cmd.finish  = 1'b1;
        end
      end
      S_EVICT_UPD: begin
        cmd.evict  = 1'b1;
        state_next = S_EVICT_CHECK;
      end
      S_READ_DESC: begin
        cmd.res_sel = vrhr_pkg::RES_LEN;
        if (flags.off_bad) begin
          cmd.finish = 1'b1;
          cmd.status = vrhr_pkg::ST_RANGE;
        end else begin
          cmd.byte_rd = 1'b1;
          state_next  = S_READ_BYTE;
        end
      end
      S_READ_BYTE: begin
        cmd.res_sel = vrhr_pkg::RES_LEN_BYTE;
        cmd.finish  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.finish) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  a_evict_loops_back: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |=> (state == S_EVICT_CHECK))
    else $error("eviction did not return to the space check");

endmodule

FILE: hdl/vrhr_datapath.sv
// ----------------------------------------------------------------------------
// vrhr_datapath: storage and bookkeeping for the record history ring
// Byte store, descriptor memory, ring pointers and result registers.
// ----------------------------------------------------------------------------
module vrhr_datapath #(
  parameter int STORE_BYTES = vrhr_pkg::STORE_BYTES_DEF,
  parameter int MAX_ENTRIES = vrhr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [vrhr_pkg::CMD_W-1:0]     command,
  input  logic [vrhr_pkg::LEN_W-1:0]     line_length,
  input  logic [vrhr_pkg::BYTE_W-1:0]    data_byte,
  input  logic [vrhr_pkg::INDEX_W-1:0]   entry_index,
  input  logic [vrhr_pkg::OFF_W-1:0]     byte_offset,
  input  vrhr_pkg::ctrl_cmd_t            cmd,
  output vrhr_pkg::dp_flags_t            flags,
  output logic [vrhr_pkg::STAT_W-1:0]    status,
  output logic [vrhr_pkg::COUNT_W-1:0]   entry_count,
  output logic [vrhr_pkg::LEN_W-1:0]     read_length,
  output logic [vrhr_pkg::BYTE_W-1:0]    read_byte
);

  localparam int AW   = $clog2(STORE_BYTES);      // byte address
  localparam int MW   = $clog2(MAX_ENTRIES);      // descriptor slot
  localparam int HW   = $clog2(MAX_ENTRIES + 1);  // held count
  localparam int FW   = $clog2(STORE_BYTES + 1);  // free bytes
  localparam int LW   = vrhr_pkg::LEN_W;
  localparam int BAW  = ((AW > vrhr_pkg::OFF_W) ? AW : vrhr_pkg::OFF_W) + 1;
  localparam int RSW  = ((MW > vrhr_pkg::INDEX_W) ? MW : vrhr_pkg::INDEX_W) + 1;
  localparam int HALF = STORE_BYTES / 2;

  // descriptor and byte memories
  logic [vrhr_pkg::BYTE_W-1:0] byte_mem [STORE_BYTES];
  logic [AW-1:0]               start_mem [MAX_ENTRIES];
  logic [LW-1:0]               len_mem [MAX_ENTRIES];

  // ring bookkeeping
  logic [MW-1:0] oldest_slot;
  logic [HW-1:0] held_count, held_count_next;
  logic [FW-1:0] free_bytes;
  logic [AW-1:0] write_head;
  logic [LW-1:0] bytes_left;
  logic          add_open;

  // captured transaction
  logic [vrhr_pkg::CMD_W-1:0]   cmd_q;
  logic [LW-1:0]                len_q;
  logic [vrhr_pkg::BYTE_W-1:0]  data_q;
  logic [vrhr_pkg::INDEX_W-1:0] idx_q;
  logic [vrhr_pkg::OFF_W-1:0]   off_q;

  // registered memory read data
  logic [AW-1:0]               desc_start_rd;
  logic [LW-1:0]               desc_len_rd;
  logic [vrhr_pkg::BYTE_W-1:0] byte_rd;

  logic [RSW-1:0] read_slot_sum;
  logic [MW-1:0]  read_slot;
  logic [MW:0]    new_slot_sum;
  logic [MW-1:0]  new_slot;
  logic [MW-1:0]  desc_rd_addr;
  logic [BAW-1:0] byte_addr_sum;
  logic [AW-1:0]  byte_rd_addr;

  always_comb begin
    read_slot_sum = RSW'(oldest_slot) + RSW'(idx_q);
    if (read_slot_sum >= RSW'(MAX_ENTRIES)) begin
      read_slot_sum = read_slot_sum - RSW'(MAX_ENTRIES);
    end
    read_slot = MW'(read_slot_sum);

    new_slot_sum = (MW + 1)'(oldest_slot) + (MW + 1)'(held_count);
    if (new_slot_sum >= (MW + 1)'(MAX_ENTRIES)) begin
      new_slot_sum = new_slot_sum - (MW + 1)'(MAX_ENTRIES);
    end
    new_slot = MW'(new_slot_sum);

    desc_rd_addr = (cmd_q == vrhr_pkg::CMD_READ) ? read_slot : oldest_slot;

    // offset is below the length, which is below half the store
    byte_addr_sum = BAW'(desc_start_rd) + BAW'(off_q);
    if (byte_addr_sum >= BAW'(STORE_BYTES)) begin
      byte_addr_sum = byte_addr_sum - BAW'(STORE_BYTES);
    end
    byte_rd_addr = AW'(byte_addr_sum);
  end

  always_comb begin
    flags.cmd_code   = cmd_q;
    flags.add_open   = add_open;
    flags.too_long   = (32'(len_q) >= 32'(HALF));
    flags.idx_bad    = (32'(idx_q) >= 32'(held_count));
    flags.need_evict = (held_count != '0) &&
                       ((32'(free_bytes) < 32'(len_q)) ||
                        (32'(held_count) >= 32'(MAX_ENTRIES)));
    flags.off_bad    = (32'(off_q) >= 32'(desc_len_rd));
  end

  always_comb begin
    held_count_next = held_count;
    if (cmd.desc_wr && (len_q == '0)) begin
      held_count_next = held_count + HW'(1);
    end else if (cmd.byte_wr && (bytes_left == LW'(1))) begin
      held_count_next = held_count + HW'(1);
    end else if (cmd.evict) begin
      held_count_next = held_count - HW'(1);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      byte_mem[write_head] <= data_q;
    end
    if (cmd.byte_rd) begin
      byte_rd <= byte_mem[byte_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.desc_wr) begin
      start_mem[new_slot] <= write_head;
      len_mem[new_slot]   <= len_q;
    end
    if (cmd.desc_rd) begin
      desc_start_rd <= start_mem[desc_rd_addr];
      desc_len_rd   <= len_mem[desc_rd_addr];
    end
  end

  // transaction capture and results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q  <= command;
      len_q  <= line_length;
      data_q <= data_byte;
      idx_q  <= entry_index;
      off_q  <= byte_offset;
    end
    if (cmd.finish) begin
      status      <= cmd.status;
      entry_count <= vrhr_pkg::COUNT_W'(held_count_next);
      read_length <= (cmd.res_sel != vrhr_pkg::RES_NONE) ? desc_len_rd : '0;
      read_byte   <= (cmd.res_sel == vrhr_pkg::RES_LEN_BYTE) ? byte_rd : '0;
    end
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot <= '0;
      held_count  <= '0;
      free_bytes  <= FW'(STORE_BYTES);
      write_head  <= '0;
      bytes_left  <= '0;
      add_open    <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (cmd.evict) begin
        free_bytes  <= free_bytes + FW'(desc_len_rd);
        oldest_slot <= (oldest_slot == MW'(MAX_ENTRIES - 1)) ? '0 : oldest_slot + MW'(1);
      end
      if (cmd.desc_wr) begin
        free_bytes <= free_bytes - FW'(len_q);
        if (len_q != '0) begin
          add_open   <= 1'b1;
          bytes_left <= len_q;
        end
      end
      if (cmd.byte_wr) begin
        write_head <= (write_head == AW'(STORE_BYTES - 1)) ? '0 : write_head + AW'(1);
        bytes_left <= bytes_left - LW'(1);
        if (bytes_left == LW'(1)) begin
          add_open <= 1'b0;
        end
      end
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    32'(held_count) <= 32'(MAX_ENTRIES))
    else $error("held entry count exceeds descriptor ring");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_bytes) <= 32'(STORE_BYTES))
    else $error("free byte count exceeds store size");

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    add_open |-> (bytes_left != '0))
    else $error("open add with no bytes left");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the record history ring
// Drives begin/add/read transactions over the start/busy handshake, predicts
// each result in a scoreboard, and checks every done strobe field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_BYTES = vrhr_pkg::STORE_BYTES_DEF;
  localparam int MAX_ENTRIES = vrhr_pkg::MAX_ENTRIES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [vrhr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [vrhr_pkg::STAT_W-1:0]  status;
    logic [vrhr_pkg::COUNT_W-1:0] count;
    logic [vrhr_pkg::LEN_W-1:0]   rlen;
    logic [vrhr_pkg::BYTE_W-1:0]  rbyte;
  } outcome_t;

  class ring_scoreboard;
    logic [vrhr_pkg::BYTE_W-1:0] store_mem [STORE_BYTES];
    bit [11:0]                   line_start [MAX_ENTRIES];
    bit [vrhr_pkg::LEN_W-1:0]    line_len [MAX_ENTRIES];
    bit [5:0]                    oldest;
    bit [6:0]                    held;
    bit [12:0]                   free_cnt;
    bit [11:0]                   head;
    bit [vrhr_pkg::LEN_W-1:0]    left;
    bit                          open;
    outcome_t                    expected_q[$];
    int                          errors;

    function new();
      oldest   = '0;
      held     = '0;
      free_cnt = 13'(STORE_BYTES);
      head     = '0;
      left     = '0;
      open     = 1'b0;
      errors   = 0;
    endfunction

    function bit [vrhr_pkg::LEN_W-1:0] length_of(bit [5:0] idx);
      bit [5:0] slot;
      slot = oldest + idx;
      return line_len[slot];
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // predict the result of one accepted transaction
    function void note_transaction(logic [vrhr_pkg::CMD_W-1:0] cmd,
                                   logic [vrhr_pkg::LEN_W-1:0] len,
                                   logic [vrhr_pkg::BYTE_W-1:0] dat,
                                   logic [vrhr_pkg::INDEX_W-1:0] idx,
                                   logic [vrhr_pkg::OFF_W-1:0] off);
      outcome_t o;
      bit [5:0] slot;
      bit [11:0] addr;
      o = '{vrhr_pkg::ST_OK, '0, '0, '0};
      case (cmd)
        vrhr_pkg::CMD_BEGIN: begin
          if (open) o.status = vrhr_pkg::ST_ADD_OPEN;
          else if (len >= STORE_BYTES / 2) o.status = vrhr_pkg::ST_TOO_LONG;
          else begin
            // drop oldest lines until the new one fits and a slot is free
            while (held > 0 && (free_cnt < len || held >= MAX_ENTRIES)) begin
              free_cnt = free_cnt + line_len[oldest];
              held     = held - 1'b1;
              oldest   = oldest + 1'b1;
            end
            slot = oldest + held[5:0];
            line_start[slot] = head;
            line_len[slot]   = len;
            free_cnt = free_cnt - len;
            if (len == 0) held = held + 1'b1;
            else begin
              open = 1'b1;
              left = len;
            end
          end
        end
        vrhr_pkg::CMD_ADD: begin
          if (!open) o.status = vrhr_pkg::ST_NO_ADD;
          else begin
            store_mem[head] = dat;
            head = head + 1'b1;
            left = left - 1'b1;
            if (left == 0) begin
              open = 1'b0;
              held = held + 1'b1;
            end
          end
        end
        vrhr_pkg::CMD_READ: begin
          if (idx >= held) o.status = vrhr_pkg::ST_RANGE;
          else begin
            slot   = oldest + idx;
            o.rlen = line_len[slot];
            if (off >= o.rlen) o.status = vrhr_pkg::ST_RANGE;
            else begin
              addr    = line_start[slot] + 12'(off);
              o.rbyte = store_mem[addr];
            end
          end
        end
        default: o.status = vrhr_pkg::ST_RANGE;
      endcase
      o.count = held;
      expected_q.push_back(o);
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(logic [vrhr_pkg::STAT_W-1:0] st, logic [vrhr_pkg::COUNT_W-1:0] cnt,
                      logic [vrhr_pkg::LEN_W-1:0] rl, logic [vrhr_pkg::BYTE_W-1:0] rb);
      outcome_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, status %0h", st));
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", 32'(st), 32'(e.status));
      compare_field("entry_count", 32'(cnt), 32'(e.count));
      compare_field("read_length", 32'(rl), 32'(e.rlen));
      compare_field("read_byte", 32'(rb), 32'(e.rbyte));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [vrhr_pkg::CMD_W-1:0]    command = vrhr_pkg::CMD_READ;
  logic [vrhr_pkg::LEN_W-1:0]    line_length = '0;
  logic [vrhr_pkg::BYTE_W-1:0]   data_byte = '0;
  logic [vrhr_pkg::INDEX_W-1:0]  entry_index = '0;
  logic [vrhr_pkg::OFF_W-1:0]    byte_offset = '0;
  logic                          done;
  logic [vrhr_pkg::STAT_W-1:0]   status;
  logic [vrhr_pkg::COUNT_W-1:0]  entry_count;
  logic [vrhr_pkg::LEN_W-1:0]    read_length;
  logic [vrhr_pkg::BYTE_W-1:0]   read_byte;

  ring_scoreboard sb;
  int send_idle_pct = 0;
  int items_sent = 0;
  int stall_cycles = 0;

  variable_record_history_ring_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .line_length (line_length),
    .data_byte   (data_byte),
    .entry_index (entry_index),
    .byte_offset (byte_offset),
    .done        (done),
    .status      (status),
    .entry_count (entry_count),
    .read_length (read_length),
    .read_byte   (read_byte)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, entry_count, read_length, read_byte);
  end

  // watchdog: cycles with neither an accepted transaction nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // start stays high from one transaction to the next unless a gap is drawn
  task automatic issue(input logic [vrhr_pkg::CMD_W-1:0] cmd,
                       input logic [vrhr_pkg::LEN_W-1:0] len,
                       input logic [vrhr_pkg::BYTE_W-1:0] dat,
                       input logic [vrhr_pkg::INDEX_W-1:0] idx,
                       input logic [vrhr_pkg::OFF_W-1:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    line_length <= len;
    data_byte   <= dat;
    entry_index <= idx;
    byte_offset <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    sb.note_transaction(cmd, len, dat, idx, off);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [vrhr_pkg::LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 80) return vrhr_pkg::LEN_W'($urandom_range(6, 1));
    if (r < 95) return vrhr_pkg::LEN_W'($urandom_range(40, 7));
    return vrhr_pkg::LEN_W'($urandom_range(300, 41));
  endfunction

  task automatic random_read();
    int r;
    logic [vrhr_pkg::INDEX_W-1:0] idx;
    logic [vrhr_pkg::OFF_W-1:0] off;
    logic [vrhr_pkg::LEN_W-1:0] llen;
    r = $urandom_range(99);
    if (sb.held == 0 || r < 15) begin
      // index past the newest complete entry, or any index when the ring is full
      idx = (sb.held >= MAX_ENTRIES) ? vrhr_pkg::INDEX_W'($urandom_range(63))
                                     : vrhr_pkg::INDEX_W'($urandom_range(63, sb.held));
      off = vrhr_pkg::OFF_W'($urandom_range(2047));
    end else begin
      idx  = vrhr_pkg::INDEX_W'($urandom_range(sb.held - 1));
      llen = sb.length_of(idx);
      if (r < 30 || llen == 0) off = vrhr_pkg::OFF_W'($urandom_range(2047, llen));
      else off = vrhr_pkg::OFF_W'($urandom_range(llen - 1));
    end
    issue(vrhr_pkg::CMD_READ, vrhr_pkg::LEN_W'($urandom), vrhr_pkg::BYTE_W'($urandom),
          idx, off);
  endtask

  // one line: begin, then its bytes with reads mixed in; a broken line gets
  // a refused begin somewhere in the middle
  task automatic send_line(input logic [vrhr_pkg::LEN_W-1:0] len, input bit broken);
    int cut;
    cut = (len != 0) ? $urandom_range(len - 1) : 0;
    issue(vrhr_pkg::CMD_BEGIN, len, vrhr_pkg::BYTE_W'($urandom),
          vrhr_pkg::INDEX_W'($urandom), vrhr_pkg::OFF_W'($urandom));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 12) random_read();
      if (broken && i == cut)
        issue(vrhr_pkg::CMD_BEGIN, vrhr_pkg::LEN_W'($urandom), vrhr_pkg::BYTE_W'($urandom),
              vrhr_pkg::INDEX_W'($urandom), vrhr_pkg::OFF_W'($urandom));
      issue(vrhr_pkg::CMD_ADD, vrhr_pkg::LEN_W'($urandom), vrhr_pkg::BYTE_W'($urandom),
            vrhr_pkg::INDEX_W'($urandom), vrhr_pkg::OFF_W'($urandom));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int quota);
    int r;
    int goal;
    send_idle_pct = idle_pct;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 62) send_line(pick_len(), r < 8);
      else if (r < 82) random_read();
      else if (r < 99)
        issue((r < 92) ? vrhr_pkg::CMD_ADD : CMD_UNUSED, vrhr_pkg::LEN_W'($urandom),
              vrhr_pkg::BYTE_W'($urandom), vrhr_pkg::INDEX_W'($urandom),
              vrhr_pkg::OFF_W'($urandom));
      else drain();
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 38;
    issue(vrhr_pkg::CMD_READ, '0, '0, '0, '0);        // read with nothing held
    issue(vrhr_pkg::CMD_ADD, '0, 8'hFF, '0, '0);      // byte with no add open
    issue(CMD_UNUSED, '1, '1, '1, '1);
    issue(vrhr_pkg::CMD_BEGIN, '0, '0, '0, '0);       // empty line, counted at once
    issue(vrhr_pkg::CMD_READ, '0, '0, '0, '0);        // offset past an empty line
    issue(vrhr_pkg::CMD_BEGIN, 11'd3, '0, '0, '0);
    issue(vrhr_pkg::CMD_READ, '0, '0, '0, '0);        // read while a line is open
    issue(vrhr_pkg::CMD_ADD, '0, 8'h00, '0, '0);
    issue(vrhr_pkg::CMD_BEGIN, 11'd5, '0, '0, '0);    // refused: add still open
    issue(vrhr_pkg::CMD_ADD, '0, 8'hFF, '0, '0);
    issue(vrhr_pkg::CMD_ADD, '0, 8'hA5, '0, '0);
    issue(vrhr_pkg::CMD_READ, '0, '0, 6'd1, 11'd2);
    issue(vrhr_pkg::CMD_READ, '0, '0, 6'd1, 11'd3);   // offset equal to length
    issue(vrhr_pkg::CMD_READ, '0, '0, 6'd1, '1);
    issue(vrhr_pkg::CMD_READ, '0, '0, '1, '1);
    issue(vrhr_pkg::CMD_ADD, '1, 8'h5A, '1, '1);
    drain();

    run_phase(38, 500);
    run_phase(46, 500);

    // a long line, back to back, with a refused begin in the middle
    send_idle_pct = 0;
    send_line(11'd300, 1'b1);
    run_phase(0, 250);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.report_mismatch("results still outstanding at end");
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/vrhr_pkg.sv
hdl/vrhr_ctrl.sv
hdl/vrhr_datapath.sv
hdl/variable_record_history_ring_top.sv
bench/tb_top.sv
